// ===== rtl/ssh_pkg.sv =====
package ssh_pkg;

   localparam int COORD_BITS = 32;
   localparam int R_W        = COORD_BITS - 1;
   localparam int MAG_W      = COORD_BITS + 1;
   localparam int SUM_W      = 2 * MAG_W;
   localparam int RR_W       = 2 * R_W;
   localparam int ROOT_W     = MAG_W + 1;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 2;
   localparam int QUO_W      = ROOT_W + 1;
   localparam int NUM_W      = QUO_W + MAG_W;
   localparam int PP_W       = 2 * QUO_W;
   localparam int V_W        = QUO_W + 2;
   localparam int NLANE      = 3;

   typedef logic [NLANE-1:0][COORD_BITS-1:0] ssh_coord_vec_type;
   typedef logic [NLANE-1:0][MAG_W-1:0]      ssh_mag_vec_type;

   typedef struct packed {
      ssh_coord_vec_type  start;
      ssh_mag_vec_type    dmag;
      logic [NLANE-1:0]   dneg;
      logic [SUM_W-1:0]   ww;
      logic [RR_W-1:0]    rr;
      logic [NUM_W-1:0]   dw;
      logic               in_sphere;
      logic               miss;
      logic [ROOT_W-1:0]  len;
      logic [QUO_W-1:0]   p;
   } ssh_side_type;

endpackage

// ===== rtl/ssh_sqrt.sv =====
module ssh_sqrt import ssh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [RAD_W-1:0]   in_rad,
   input  ssh_side_type       in_side,
   output logic               out_valid,
   output logic [ROOT_W-1:0]  out_root,
   output ssh_side_type       out_side
);

   logic [ROOT_W-1:0] valid_ff;
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   ssh_side_type      side_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              vprev;
      logic [RAD_W-1:0]  radprev;
      logic [REM_W-1:0]  remprev;
      logic [ROOT_W-1:0] rootprev;
      ssh_side_type      sideprev;
      logic [REM_W+1:0]  rem_sh;
      logic [REM_W+1:0]  trial;
      logic              ge;
      logic [RAD_W-1:0]  rad_in;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         always_comb begin
            vprev    = in_valid;
            radprev  = in_rad;
            remprev  = '0;
            rootprev = '0;
            sideprev = in_side;
         end
      end else begin : g_next
         always_comb begin
            vprev    = valid_ff[k-1];
            radprev  = rad_ff[k-1];
            remprev  = rem_ff[k-1];
            rootprev = root_ff[k-1];
            sideprev = side_ff[k-1];
         end
      end

      // one result bit per stage
      always_comb begin
         rem_sh  = {remprev, radprev[RAD_W-1 -: 2]};
         trial   = {2'b00, rootprev, 2'b01};
         ge      = rem_sh >= trial;
         rem_in  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
         root_in = {rootprev[ROOT_W-2:0], ge};
         rad_in  = radprev << 2;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= vprev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= sideprev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// ===== rtl/ssh_div.sv =====
module ssh_div import ssh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [ROOT_W-1:0]  in_den,
   input  ssh_side_type       in_side,
   output logic               out_valid,
   output logic [QUO_W-1:0]   out_quo,
   output ssh_side_type       out_side
);

   logic [QUO_W-1:0]  valid_ff;
   logic [QUO_W-1:0]  num_ff  [QUO_W];
   logic [ROOT_W-1:0] rem_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [ROOT_W-1:0] den_ff  [QUO_W];
   ssh_side_type      side_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic              vprev;
      logic [QUO_W-1:0]  numprev;
      logic [ROOT_W-1:0] remprev;
      logic [QUO_W-1:0]  quoprev;
      logic [ROOT_W-1:0] denprev;
      ssh_side_type      sideprev;
      logic [ROOT_W:0]   rem_sh;
      logic [ROOT_W:0]   dvs;
      logic              ge;
      logic [QUO_W-1:0]  num_in;
      logic [ROOT_W-1:0] rem_in;
      logic [QUO_W-1:0]  quo_in;

      if (k == 0) begin : g_first
         // upper numerator bits stay below the divisor
         always_comb begin
            vprev    = in_valid;
            numprev  = in_num[QUO_W-1:0];
            remprev  = ROOT_W'(in_num[NUM_W-1:QUO_W]);
            quoprev  = '0;
            denprev  = in_den;
            sideprev = in_side;
         end
      end else begin : g_next
         always_comb begin
            vprev    = valid_ff[k-1];
            numprev  = num_ff[k-1];
            remprev  = rem_ff[k-1];
            quoprev  = quo_ff[k-1];
            denprev  = den_ff[k-1];
            sideprev = side_ff[k-1];
         end
      end

      always_comb begin
         rem_sh = {remprev, numprev[QUO_W-1]};
         dvs    = {1'b0, denprev};
         ge     = rem_sh >= dvs;
         rem_in = ge ? ROOT_W'(rem_sh - dvs) : ROOT_W'(rem_sh);
         quo_in = {quoprev[QUO_W-2:0], ge};
         num_in = numprev << 1;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= vprev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k]  <= num_in;
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            den_ff[k]  <= denprev;
            side_ff[k] <= sideprev;
         end
      end
   end

   assign out_valid = valid_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule

// ===== rtl/ssh_front.sv =====
module ssh_front import ssh_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic [COORD_BITS-1:0]  start_x,
   input  logic [COORD_BITS-1:0]  start_y,
   input  logic [COORD_BITS-1:0]  start_z,
   input  logic [COORD_BITS-1:0]  end_x,
   input  logic [COORD_BITS-1:0]  end_y,
   input  logic [COORD_BITS-1:0]  end_z,
   input  logic [COORD_BITS-1:0]  center_x,
   input  logic [COORD_BITS-1:0]  center_y,
   input  logic [COORD_BITS-1:0]  center_z,
   input  logic [R_W-1:0]         radius,
   output logic                   out_valid,
   output logic [RAD_W-1:0]       out_rad,
   output ssh_side_type           out_side
);

   function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W-1:0] v);
      return v[MAG_W-1] ? MAG_W'(-v) : v;
   endfunction

   ssh_coord_vec_type s_vec, e_vec, c_vec;

   // stage a: differences
   logic              a_valid_ff;
   ssh_coord_vec_type a_start_ff;
   ssh_mag_vec_type   a_d_ff, a_w_ff;
   logic [R_W-1:0]    a_r_ff;
   ssh_mag_vec_type   a_d_in, a_w_in;

   // stage b: products
   logic                          b_valid_ff;
   ssh_coord_vec_type             b_start_ff;
   ssh_mag_vec_type               b_dmag_ff;
   logic [NLANE-1:0]              b_dneg_ff, b_same_ff;
   logic [NLANE-1:0][SUM_W-1:0]   b_wsq_ff, b_dsq_ff, b_dwm_ff;
   logic [RR_W-1:0]               b_rr_ff;
   ssh_mag_vec_type               b_dmag_in, b_wmag_in;

   // stage c: sums and early decisions
   logic              c_valid_ff;
   logic [RAD_W-1:0]  c_rad_ff;
   ssh_side_type      c_side_ff;
   logic [SUM_W-1:0]  ww_in, dd_in, dwp_in, dwn_in;
   ssh_side_type      c_side_in;

   assign s_vec = {start_z, start_y, start_x};
   assign e_vec = {end_z, end_y, end_x};
   assign c_vec = {center_z, center_y, center_x};

   always_comb begin
      for (int i = 0; i < NLANE; i++) begin
         a_d_in[i] = {e_vec[i][COORD_BITS-1], e_vec[i]} - {s_vec[i][COORD_BITS-1], s_vec[i]};
         a_w_in[i] = {c_vec[i][COORD_BITS-1], c_vec[i]} - {s_vec[i][COORD_BITS-1], s_vec[i]};
      end
   end

   always_comb begin
      for (int i = 0; i < NLANE; i++) begin
         b_dmag_in[i] = mag_of(a_d_ff[i]);
         b_wmag_in[i] = mag_of(a_w_ff[i]);
      end
   end

   always_comb begin
      ww_in  = '0;
      dd_in  = '0;
      dwp_in = '0;
      dwn_in = '0;
      for (int i = 0; i < NLANE; i++) begin
         ww_in = ww_in + b_wsq_ff[i];
         dd_in = dd_in + b_dsq_ff[i];
         if (b_same_ff[i]) begin
            dwp_in = dwp_in + b_dwm_ff[i];
         end else begin
            dwn_in = dwn_in + b_dwm_ff[i];
         end
      end
      c_side_in           = '0;
      c_side_in.start     = b_start_ff;
      c_side_in.dmag      = b_dmag_ff;
      c_side_in.dneg      = b_dneg_ff;
      c_side_in.ww        = ww_in;
      c_side_in.rr        = b_rr_ff;
      c_side_in.in_sphere = ww_in <= SUM_W'(b_rr_ff);
      // zero length or sphere behind the start
      c_side_in.miss   = (dd_in == '0) || (dwn_in > dwp_in);
      c_side_in.dw     = (dwn_in > dwp_in) ? '0 : NUM_W'(dwp_in - dwn_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_start_ff <= s_vec;
         a_d_ff     <= a_d_in;
         a_w_ff     <= a_w_in;
         a_r_ff     <= radius;
         b_start_ff <= a_start_ff;
         b_dmag_ff  <= b_dmag_in;
         b_rr_ff    <= RR_W'(a_r_ff) * RR_W'(a_r_ff);
         for (int i = 0; i < NLANE; i++) begin
            b_dneg_ff[i] <= a_d_ff[i][MAG_W-1];
            b_same_ff[i] <= a_d_ff[i][MAG_W-1] == a_w_ff[i][MAG_W-1];
            b_wsq_ff[i]  <= SUM_W'(b_wmag_in[i]) * SUM_W'(b_wmag_in[i]);
            b_dsq_ff[i]  <= SUM_W'(b_dmag_in[i]) * SUM_W'(b_dmag_in[i]);
            b_dwm_ff[i]  <= SUM_W'(b_dmag_in[i]) * SUM_W'(b_wmag_in[i]);
         end
         c_rad_ff   <= RAD_W'(dd_in);
         c_side_ff  <= c_side_in;
      end
   end

   assign out_valid = c_valid_ff;
   assign out_rad   = c_rad_ff;
   assign out_side  = c_side_ff;

endmodule

// ===== rtl/segment_sphere_hit_point_core.sv =====
// segment against sphere, first contact point
//
// req_ channel: one query per transfer, a segment (start, end), a sphere
// centre and a radius, all raw Q15.16. rsp_ channel: one result per query,
// hit flag and contact point, contact zero when there is no hit. Results
// come out in query order.
//
// a query passes from the req_ transfer to rsp_valid through three
// front stages (differences, products, sums), the segment length root (34
// stages), the projection divider (35), two stages for the side distance,
// the entry root (34), two stages for the entry distance, three offset
// dividers in parallel (35) and the result register.
// throughput: one query per cycle unless stalled; all stages move together.
//
// reset clears every valid bit, so the pipe comes up empty. when rsp_ready
// is low with a result waiting, the whole pipe holds and req_ready drops in
// the same cycle; nothing is lost or repeated.
module segment_sphere_hit_point_core import ssh_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [COORD_BITS-1:0]  req_start_x,
   input  logic [COORD_BITS-1:0]  req_start_y,
   input  logic [COORD_BITS-1:0]  req_start_z,
   input  logic [COORD_BITS-1:0]  req_end_x,
   input  logic [COORD_BITS-1:0]  req_end_y,
   input  logic [COORD_BITS-1:0]  req_end_z,
   input  logic [COORD_BITS-1:0]  req_center_x,
   input  logic [COORD_BITS-1:0]  req_center_y,
   input  logic [COORD_BITS-1:0]  req_center_z,
   input  logic [R_W-1:0]         req_radius,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit,
   output logic [COORD_BITS-1:0]  rsp_contact_x,
   output logic [COORD_BITS-1:0]  rsp_contact_y,
   output logic [COORD_BITS-1:0]  rsp_contact_z
);

   logic adv;

   logic              fr_valid;
   logic [RAD_W-1:0]  fr_rad;
   ssh_side_type      fr_side;

   logic              len_valid;
   logic [ROOT_W-1:0] len_root;
   ssh_side_type      len_side;
   ssh_side_type      pd_side;

   logic              p_valid;
   logic [QUO_W-1:0]  p_quo;
   ssh_side_type      p_side;

   logic              p1_valid_ff;
   ssh_side_type      p1_side_ff;
   logic [PP_W-1:0]   p1_pp_ff;
   ssh_side_type      p1_side_in;

   logic              p2_valid_ff;
   ssh_side_type      p2_side_ff;
   logic [RAD_W-1:0]  p2_rad_ff;
   logic [SUM_W-1:0]  h2;
   ssh_side_type      p2_side_in;
   logic [RAD_W-1:0]  p2_rad_in;

   logic              q_valid;
   logic [ROOT_W-1:0] q_root;
   ssh_side_type      q_side;

   logic              d1_valid_ff;
   ssh_side_type      d1_side_ff;
   logic [QUO_W-1:0]  d1_dist_ff;
   logic [QUO_W-1:0]  d1_dist_in;

   logic                        d2_valid_ff;
   ssh_side_type                d2_side_ff;
   logic [NLANE-1:0][NUM_W-1:0] d2_num_ff;

   logic [NLANE-1:0]  off_valid;
   logic [QUO_W-1:0]  off_quo  [NLANE];
   ssh_side_type      off_side [NLANE];

   logic                   rsp_valid_ff, rsp_hit_ff;
   ssh_coord_vec_type      rsp_contact_ff;
   ssh_coord_vec_type      contact_in;
   logic                   hit_in;
   logic signed [V_W-1:0]  hi_v, lo_v;
   logic signed [V_W-1:0]  v_tmp [NLANE];

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   ssh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_valid),
      .start_x   (req_start_x),
      .start_y   (req_start_y),
      .start_z   (req_start_z),
      .end_x     (req_end_x),
      .end_y     (req_end_y),
      .end_z     (req_end_z),
      .center_x  (req_center_x),
      .center_y  (req_center_y),
      .center_z  (req_center_z),
      .radius    (req_radius),
      .out_valid (fr_valid),
      .out_rad   (fr_rad),
      .out_side  (fr_side)
   );

   ssh_sqrt u_len (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (fr_valid),
      .in_rad    (fr_rad),
      .in_side   (fr_side),
      .out_valid (len_valid),
      .out_root  (len_root),
      .out_side  (len_side)
   );

   always_comb begin
      pd_side     = len_side;
      pd_side.len = len_root;
   end

   ssh_div u_proj (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (len_valid),
      .in_num    (len_side.dw),
      .in_den    (len_root),
      .in_side   (pd_side),
      .out_valid (p_valid),
      .out_quo   (p_quo),
      .out_side  (p_side)
   );

   always_comb begin
      p1_side_in   = p_side;
      p1_side_in.p = p_quo;
   end

   // side distance and the range checks
   always_comb begin
      h2 = (PP_W'(p1_side_ff.ww) > p1_pp_ff) ? SUM_W'(PP_W'(p1_side_ff.ww) - p1_pp_ff) : '0;
      p2_side_in      = p1_side_ff;
      p2_side_in.miss = p1_side_ff.miss || (h2 > SUM_W'(p1_side_ff.rr)) ||
                        (p1_side_ff.p >= QUO_W'(p1_side_ff.len));
      p2_rad_in = p2_side_in.miss ? '0 : RAD_W'(SUM_W'(p1_side_ff.rr) - h2);
   end

   ssh_sqrt u_entry (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p2_valid_ff),
      .in_rad    (p2_rad_ff),
      .in_side   (p2_side_ff),
      .out_valid (q_valid),
      .out_root  (q_root),
      .out_side  (q_side)
   );

   assign d1_dist_in = (q_side.p > QUO_W'(q_root)) ? QUO_W'(q_side.p - QUO_W'(q_root)) : '0;

   for (genvar i = 0; i < NLANE; i++) begin : g_lane
      ssh_div u_off (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (d2_valid_ff),
         .in_num    (d2_num_ff[i]),
         .in_den    (d2_side_ff.len),
         .in_side   (d2_side_ff),
         .out_valid (off_valid[i]),
         .out_quo   (off_quo[i]),
         .out_side  (off_side[i])
      );
   end

   // step along each axis and saturate
   always_comb begin
      hi_v   = V_W'(signed'({1'b0, {(COORD_BITS-1){1'b1}}}));
      lo_v   = V_W'(signed'({1'b1, {(COORD_BITS-1){1'b0}}}));
      hit_in = off_side[0].in_sphere || !off_side[0].miss;
      for (int i = 0; i < NLANE; i++) begin
         v_tmp[i] = off_side[0].dneg[i] ?
                    V_W'(signed'(off_side[0].start[i])) - signed'(V_W'(off_quo[i])) :
                    V_W'(signed'(off_side[0].start[i])) + signed'(V_W'(off_quo[i]));
         if (!hit_in) begin
            contact_in[i] = '0;
         end else if (off_side[0].in_sphere) begin
            contact_in[i] = off_side[0].start[i];
         end else if (v_tmp[i] > hi_v) begin
            contact_in[i] = hi_v[COORD_BITS-1:0];
         end else if (v_tmp[i] < lo_v) begin
            contact_in[i] = lo_v[COORD_BITS-1:0];
         end else begin
            contact_in[i] = v_tmp[i][COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         d1_valid_ff  <= 1'b0;
         d2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff  <= p_valid;
         p2_valid_ff  <= p1_valid_ff;
         d1_valid_ff  <= q_valid;
         d2_valid_ff  <= d1_valid_ff;
         rsp_valid_ff <= off_valid[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_side_ff     <= p1_side_in;
         p1_pp_ff       <= PP_W'(p_quo) * PP_W'(p_quo);
         p2_side_ff     <= p2_side_in;
         p2_rad_ff      <= p2_rad_in;
         d1_side_ff     <= q_side;
         d1_dist_ff     <= d1_dist_in;
         d2_side_ff     <= d1_side_ff;
         for (int i = 0; i < NLANE; i++) begin
            d2_num_ff[i] <= NUM_W'(d1_dist_ff) * NUM_W'(d1_side_ff.dmag[i]);
         end
         rsp_hit_ff     <= hit_in;
         rsp_contact_ff <= contact_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_contact_x = rsp_contact_ff[0];
   assign rsp_contact_y = rsp_contact_ff[1];
   assign rsp_contact_z = rsp_contact_ff[2];

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      off_valid[0] == off_valid[1] && off_valid[0] == off_valid[2])
      else $error("offset lanes out of step");

   a_lanes_same_query: assert property (@(posedge clock) disable iff (reset)
      off_valid[0] |-> off_side[1] == off_side[0] && off_side[2] == off_side[0])
      else $error("offset lanes carry different queries");

   a_entry_root_range: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_side.miss |-> q_root[ROOT_W-1:R_W] == '0)
      else $error("entry root exceeds radius range");

   a_offset_below_len: assert property (@(posedge clock) disable iff (reset)
      off_valid[0] && !off_side[0].in_sphere && !off_side[0].miss |->
      off_quo[0] < QUO_W'(off_side[0].len))
      else $error("offset beyond segment length");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |->
      rsp_contact_x == '0 && rsp_contact_y == '0 && rsp_contact_z == '0)
      else $error("contact point set without a hit");

endmodule

// ===== test/segment_sphere_hit_point_checker.sv =====
`timescale 1ns / 1ps
module segment_sphere_hit_point_checker import ssh_pkg::*; (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [NLANE-1:0][COORD_BITS-1:0]     req_start,
   input  logic [NLANE-1:0][COORD_BITS-1:0]     req_end,
   input  logic [NLANE-1:0][COORD_BITS-1:0]     req_center,
   input  logic [R_W-1:0]                       req_radius,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic                                 rsp_hit,
   input  logic [NLANE-1:0][COORD_BITS-1:0]     rsp_contact,
   output int                                   errors,
   output int                                   pending
);

   typedef struct {
      logic                             hit;
      logic [NLANE-1:0][COORD_BITS-1:0] contact;
   } hit_point_type;

   hit_point_type expected_hits[$];

   function automatic logic [63:0] int_root(logic [127:0] n);
      logic [63:0] res;
      logic [63:0] c;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         c = res | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) res = c;
      end
      return res;
   endfunction

   function automatic logic [127:0] wide_mul(logic [63:0] a, logic [63:0] b);
      return {64'd0, a} * {64'd0, b};
   endfunction

   function automatic hit_point_type predict_hit_point(
      logic [NLANE-1:0][COORD_BITS-1:0] s_in,
      logic [NLANE-1:0][COORD_BITS-1:0] e_in,
      logic [NLANE-1:0][COORD_BITS-1:0] c_in,
      logic [R_W-1:0]                   r);
      hit_point_type res;
      longint sv[NLANE];
      longint dv[NLANE];
      longint wv[NLANE];
      logic [63:0] dm[NLANE];
      logic [63:0] wm;
      logic [127:0] ww, dd, dwp, dwn, rr, dw, pp, h2, t;
      logic [63:0] len, p, q, gap;
      longint off, v;
      res.hit = 1'b0;
      res.contact = '0;
      ww = '0; dd = '0; dwp = '0; dwn = '0;
      for (int i = 0; i < NLANE; i++) begin
         sv[i] = longint'($signed(s_in[i]));
         dv[i] = longint'($signed(e_in[i])) - sv[i];
         wv[i] = longint'($signed(c_in[i])) - sv[i];
         dm[i] = dv[i] < 0 ? -dv[i] : dv[i];
         wm = wv[i] < 0 ? -wv[i] : wv[i];
         ww += wide_mul(wm, wm);
         dd += wide_mul(dm[i], dm[i]);
         if ((dv[i] < 0) == (wv[i] < 0)) dwp += wide_mul(dm[i], wm);
         else dwn += wide_mul(dm[i], wm);
      end
      rr = wide_mul({33'd0, r}, {33'd0, r});
      if (ww <= rr) begin
         res.hit = 1'b1;
         res.contact = s_in;
         return res;
      end
      if (dd == 0 || dwn > dwp) return res;
      dw = dwp - dwn;
      len = int_root(dd);
      t = dw / {64'd0, len};
      p = t[63:0];
      pp = wide_mul(p, p);
      h2 = (ww > pp) ? ww - pp : '0;
      if (h2 > rr || p >= len) return res;
      q = int_root(rr - h2);
      gap = (p > q) ? p - q : '0;
      for (int i = 0; i < NLANE; i++) begin
         t = wide_mul(gap, dm[i]) / {64'd0, len};
         off = longint'(t[63:0]);
         v = (dv[i] < 0) ? sv[i] - off : sv[i] + off;
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         res.contact[i] = v[COORD_BITS-1:0];
      end
      res.hit = 1'b1;
      return res;
   endfunction

   assign pending = expected_hits.size();

   initial errors = 0;

   always @(posedge clock) begin
      hit_point_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_hits = {expected_hits, predict_hit_point(req_start, req_end,
                                                              req_center, req_radius)};
         if (rsp_valid && rsp_ready) begin
            if (expected_hits.size() == 0) begin
               $error("unexpected rsp transfer");
               errors++;
            end else begin
               want = expected_hits.pop_front();
               if (rsp_hit !== want.hit) begin
                  $error("hit: expected %0d actual %0d", want.hit, rsp_hit);
                  errors++;
               end
               for (int i = 0; i < NLANE; i++)
                  if (rsp_contact[i] !== want.contact[i]) begin
                     $error("contact_%s: expected %0d actual %0d", i == 0 ? "x" :
                            i == 1 ? "y" : "z", $signed(want.contact[i]),
                            $signed(rsp_contact[i]));
                     errors++;
                  end
            end
         end
      end
   end

endmodule

// ===== test/segment_sphere_hit_point_core_tb.sv =====
`timescale 1ns / 1ps
module segment_sphere_hit_point_core_tb import ssh_pkg::*; ();

   typedef struct {
      logic [NLANE-1:0][COORD_BITS-1:0] s;
      logic [NLANE-1:0][COORD_BITS-1:0] e;
      logic [NLANE-1:0][COORD_BITS-1:0] c;
      logic [R_W-1:0]                   r;
   } query_type;

   localparam int NUM_RANDOM = 1000;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 300;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [NLANE-1:0][COORD_BITS-1:0] req_start, req_end, req_center;
   logic [R_W-1:0] req_radius;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_hit;
   logic [NLANE-1:0][COORD_BITS-1:0] rsp_contact;
   int errors;
   int pending;
   int burst_left;
   int cycles;
   int ready_mode;

   segment_sphere_hit_point_core DUT (
      .clock, .reset, .req_valid, .req_ready,
      .req_start_x(req_start[0]), .req_start_y(req_start[1]), .req_start_z(req_start[2]),
      .req_end_x(req_end[0]), .req_end_y(req_end[1]), .req_end_z(req_end[2]),
      .req_center_x(req_center[0]), .req_center_y(req_center[1]),
      .req_center_z(req_center[2]), .req_radius,
      .rsp_valid, .rsp_ready, .rsp_hit,
      .rsp_contact_x(rsp_contact[0]), .rsp_contact_y(rsp_contact[1]),
      .rsp_contact_z(rsp_contact[2])
   );

   segment_sphere_hit_point_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 250 == 0) ready_mode <= $urandom_range(0, 3);
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ((cycles / 7) % 3 != 0);
      endcase
   end

   initial begin
      @(posedge clock);
      while (cycles < CYCLE_LIMIT) @(posedge clock);
      $display("segment_sphere_hit_point_core_tb: errors");
      $finish;
   end

   function automatic longint spread(longint m);
      return longint'($urandom_range(0, 32'(2 * m))) - m;
   endfunction

   function automatic query_type make_query(logic [NLANE-1:0][COORD_BITS-1:0] s,
                                            logic [NLANE-1:0][COORD_BITS-1:0] e,
                                            logic [NLANE-1:0][COORD_BITS-1:0] c,
                                            logic [R_W-1:0] r);
      query_type q;
      q.s = s; q.e = e; q.c = c; q.r = r;
      return q;
   endfunction

   function automatic query_type random_query();
      query_type q;
      longint scale, cv, sv, ev, k;
      if ($urandom_range(0, 9) < 2) begin
         for (int i = 0; i < NLANE; i++) begin
            q.s[i] = $urandom; q.e[i] = $urandom; q.c[i] = $urandom;
         end
         q.r = R_W'($urandom);
         return q;
      end
      scale = longint'(1) << $urandom_range(2, 29);
      k = $urandom_range(0, 5);
      q.r = R_W'($urandom_range(0, 32'(scale)));
      for (int i = 0; i < NLANE; i++) begin
         cv = longint'($signed($urandom)) >>> 1;
         sv = cv + spread(3 * scale);
         ev = sv + ((cv - sv) * k) / 2 + spread(scale / 4);
         q.c[i] = cv[31:0]; q.s[i] = sv[31:0]; q.e[i] = ev[31:0];
      end
      return q;
   endfunction

   task automatic send(query_type q);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 20);
      end
      req_start <= q.s; req_end <= q.e; req_center <= q.c; req_radius <= q.r;
      req_valid <= 1'b1;
      @(posedge clock iff req_ready);
      burst_left--;
   endtask

   initial begin
      query_type directed[$];
      localparam logic [31:0] MX = 32'h7fff_ffff;
      localparam logic [31:0] MN = 32'h8000_0000;
      reset = 1'b1;
      burst_left = 0;
      req_valid <= 1'b0;
      req_start <= '0; req_end <= '0; req_center <= '0; req_radius <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // inside, zero length, behind, sideways, beyond end, plain hits, extremes
      directed = {directed, make_query('0, '0, '0, '0)};
      directed = {directed, make_query('0, '0, {3{32'd100}}, 31'd10)};
      directed = {directed, make_query('0, {3{32'd1000}}, {3{-32'sd500}}, 31'd100)};
      directed = {directed, make_query('0, {32'd0, 32'd0, 32'd1000},
                                       {32'd0, 32'd500, 32'd500}, 31'd100)};
      directed = {directed, make_query('0, {32'd0, 32'd0, 32'd100},
                                       {32'd0, 32'd0, 32'd500}, 31'd50)};
      directed = {directed, make_query('0, {32'd0, 32'd0, 32'd1000},
                                       {32'd0, 32'd0, 32'd500}, 31'd100)};
      directed = {directed, make_query('0, {32'd0, 32'd0, 32'd1000},
                                       {32'd0, 32'd0, 32'd100}, 31'd100)};
      directed = {directed, make_query({3{MN}}, {3{MX}}, '0, 31'h7fff_ffff)};
      directed = {directed, make_query({3{MX}}, {3{MN}}, '0, 31'd65536)};
      directed = {directed, make_query({3{MN}}, {3{MX}}, {3{MX}}, '0)};
      directed = {directed, make_query({MX, MN, MX}, {MN, MX, MN}, '0, 31'h4000_0000)};
      directed = {directed, make_query({3{MN}}, {3{MX}}, {3{MN}}, 31'h7fff_ffff)};
      directed = {directed, make_query({3{32'hffff_ffff}}, {3{32'd1}}, '0, 31'd1)};
      foreach (directed[i]) send(directed[i]);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == NUM_RANDOM / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            wait (pending == 0);
            burst_left = 0;
         end
         send(random_query());
      end
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0)
         $display("segment_sphere_hit_point_core_tb: clean");
      else
         $display("segment_sphere_hit_point_core_tb: errors");
      $finish;
   end

endmodule

// ===== segment_sphere_hit_point_core.f =====
rtl/ssh_pkg.sv
rtl/ssh_sqrt.sv
rtl/ssh_div.sv
rtl/ssh_front.sv
rtl/segment_sphere_hit_point_core.sv
test/segment_sphere_hit_point_checker.sv
test/segment_sphere_hit_point_core_tb.sv
